### src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Both macros report through $error with a fixed message; the label names the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define NRCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clip stack check failed");

// Checked at every rising edge, also while reset is held.
`define NRCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clip stack check failed");

`endif

### src/nrcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip rectangle stack package
// Request and response types, the rectangle type, cell control and helpers.
// ----------------------------------------------------------------------------
package nrcs_pkg;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_BEGIN     = 2'd1,
    ACT_END       = 2'd2,
    ACT_END_APPLY = 2'd3
  } action_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_e;

  localparam logic [15:0] OVF_MAX = 16'hFFFF;

  typedef struct packed {
    logic               req_type;
    logic               window_ready;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] size_w;
    logic signed [19:0] size_h;
  } req_t;

  typedef struct packed {
    action_e            action;
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic        [15:0] clip_w;
    logic        [15:0] clip_h;
    logic        [6:0]  stack_level;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] w;
    logic        [15:0] h;
  } rect_t;

  // Shift command common to every cell of the stack.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // Clamps a signed extent to the unsigned 16-bit size range.
  function automatic logic [15:0] sat_u16(input logic signed [18:0] v);
    logic [15:0] r;
    if (v < 19'sd0) begin
      r = 16'd0;
    end else if (v > 19'sd65535) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/nested_clip_rect_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested clip rectangle stack
// Stack of scissor rectangles built as a shifting row of cells.
// ----------------------------------------------------------------------------
// In the cycle in which a request is accepted, the Q16.4 rectangle is
// rounded to whole pixels and captured in a register; in the cycle after,
// it is intersected with the rectangle in the top cell, and once the output
// register is free the response is written to it and the cell row shifts
// by one place. The input stall is raised when a request is accepted and
// held until that write, which waits while a previous response still waits
// in the output register, so a new request is taken only after the previous
// one has been written out. The stack is a row of STACK_DEPTH cells: a push
// moves every rectangle one cell down and writes the new one into the top
// cell, a pop moves every rectangle one cell up. Only the top cell and the
// one below it are ever read, so cell contents past the stack level are
// never seen. Pushes beyond a full stack raise a saturating overflow count,
// which matching pops lower before the stack is touched again. A pop
// without a drawing target clears the stack and that count.
// ----------------------------------------------------------------------------
module nested_clip_rect_stack_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  nrcs_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output nrcs_pkg::rsp_t rsp_o
);
  import nrcs_pkg::*;

  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  // The cell just below the top; with a single cell it is never used.
  localparam int NEXT_IDX = (STACK_DEPTH > 1) ? 1 : 0;

  // Request handshake and the busy flag that covers the work after acceptance.
  logic accept;
  logic done;
  logic busy_q;

  // Request held from acceptance until its response is written.
  logic  pend_pop_q;
  logic  pend_ready_q;
  rect_t rnd_q;
  rect_t rnd_rect;

  // Stack bookkeeping.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      ovf_q, ovf_d;

  // Output register.
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  // Cell row.
  rect_t     cell_rect [STACK_DEPTH];
  rect_t     new_rect;
  cell_ctl_t cell_ctl;

  // Intersection with the top cell.
  rect_t              isect;
  logic signed [15:0] nx, ny;
  logic signed [17:0] top_re, top_be, new_re, new_be, re, be;
  logic [CNT_W+6:0]   lvl_ext;

  assign accept      = req_valid_i && !req_stall_o;
  assign req_stall_o = busy_q;
  assign done        = busy_q && (!rsp_valid_q || !rsp_stall_i);

  nrcs_round u_round (
    .pos_x_i  (req_i.pos_x),
    .pos_y_i  (req_i.pos_y),
    .size_w_i (req_i.size_w),
    .size_h_i (req_i.size_h),
    .rect_o   (rnd_rect)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_pop_q   <= req_i.req_type;
      pend_ready_q <= req_i.window_ready;
      rnd_q        <= rnd_rect;
    end
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        rsp_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
        ovf_q       <= ovf_d;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Intersect the rounded rectangle with the current top of the stack.
  always_comb begin
    nx     = (cell_rect[0].x > rnd_q.x) ? cell_rect[0].x : rnd_q.x;
    ny     = (cell_rect[0].y > rnd_q.y) ? cell_rect[0].y : rnd_q.y;
    top_re = 18'(cell_rect[0].x) + 18'({2'b00, cell_rect[0].w});
    top_be = 18'(cell_rect[0].y) + 18'({2'b00, cell_rect[0].h});
    new_re = 18'(rnd_q.x) + 18'({2'b00, rnd_q.w});
    new_be = 18'(rnd_q.y) + 18'({2'b00, rnd_q.h});
    re     = (top_re < new_re) ? top_re : new_re;
    be     = (top_be < new_be) ? top_be : new_be;
    isect.x = nx;
    isect.y = ny;
    isect.w = sat_u16(19'(re) - 19'(nx));
    isect.h = sat_u16(19'(be) - 19'(ny));
  end

  // Decide what the pending request does to the stack and the response.
  always_comb begin
    cnt_d          = cnt_q;
    ovf_d          = ovf_q;
    cell_ctl       = '0;
    new_rect       = (cnt_q != '0) ? isect : rnd_q;
    rsp_d          = '0;
    rsp_d.action   = ACT_NONE;

    if (pend_pop_q == REQ_PUSH) begin
      if (pend_ready_q) begin
        if (ovf_q != '0) begin
          if (ovf_q != OVF_MAX) begin
            ovf_d = ovf_q + 16'd1;
          end
        end else if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
          ovf_d = 16'd1;
        end else begin
          cnt_d          = cnt_q + CNT_W'(1);
          cell_ctl.push  = done;
          rsp_d.action   = ACT_BEGIN;
          rsp_d.clip_x   = new_rect.x;
          rsp_d.clip_y   = new_rect.y;
          rsp_d.clip_w   = new_rect.w;
          rsp_d.clip_h   = new_rect.h;
        end
      end
    end else begin
      if (!pend_ready_q) begin
        // Losing the drawing target drops the whole stack.
        cnt_d = '0;
        ovf_d = '0;
      end else if (ovf_q != '0) begin
        ovf_d = ovf_q - 16'd1;
      end else if (cnt_q != '0) begin
        cnt_d        = cnt_q - CNT_W'(1);
        cell_ctl.pop = done;
        if (cnt_q > CNT_W'(1)) begin
          // The rectangle below the top becomes the new top and is applied again.
          rsp_d.action = ACT_END_APPLY;
          rsp_d.clip_x = cell_rect[NEXT_IDX].x;
          rsp_d.clip_y = cell_rect[NEXT_IDX].y;
          rsp_d.clip_w = cell_rect[NEXT_IDX].w;
          rsp_d.clip_h = cell_rect[NEXT_IDX].h;
        end else begin
          rsp_d.action = ACT_END;
        end
      end
    end

    lvl_ext           = (CNT_W + 7)'(cnt_d);
    rsp_d.stack_level = lvl_ext[6:0];
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rect_t up_rect;
    rect_t dn_rect;

    if (i == 0) begin : g_top
      assign up_rect = new_rect;
    end else begin : g_mid
      assign up_rect = cell_rect[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn_rect = cell_rect[i];
    end else begin : g_inner
      assign dn_rect = cell_rect[i+1];
    end

    nrcs_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .up_i   (up_rect),
      .dn_i   (dn_rect),
      .rect_o (cell_rect[i])
    );
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### src/nrcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip stack cell
// Holds one rectangle; takes its upper neighbor on push, its lower on pop.
// ----------------------------------------------------------------------------
module nrcs_cell (
  input  logic               clk_i,
  input  nrcs_pkg::cell_ctl_t ctl_i,
  input  nrcs_pkg::rect_t    up_i,
  input  nrcs_pkg::rect_t    dn_i,
  output nrcs_pkg::rect_t    rect_o
);
  import nrcs_pkg::*;

  rect_t rect_q;
  rect_t rect_d;

  always_comb begin
    rect_d = rect_q;
    if (ctl_i.push) begin
      rect_d = up_i;
    end else if (ctl_i.pop) begin
      rect_d = dn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign rect_o = rect_q;

endmodule

### src/nrcs_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip rectangle rounding
// Turns a Q16.4 rectangle into whole pixels: floor left/top, ceil right/bottom.
// ----------------------------------------------------------------------------
module nrcs_round (
  input  logic signed [19:0] pos_x_i,
  input  logic signed [19:0] pos_y_i,
  input  logic signed [19:0] size_w_i,
  input  logic signed [19:0] size_h_i,
  output nrcs_pkg::rect_t    rect_o
);
  import nrcs_pkg::*;

  logic signed [19:0] w_pos, h_pos;
  logic signed [20:0] right_q4, bottom_q4;
  logic signed [21:0] right_up, bottom_up;
  logic signed [17:0] right_px, bottom_px;
  logic signed [18:0] w_ext, h_ext;

  always_comb begin
    // A negative size counts as zero.
    w_pos = size_w_i[19] ? 20'sd0 : size_w_i;
    h_pos = size_h_i[19] ? 20'sd0 : size_h_i;

    right_q4  = 21'(pos_x_i) + 21'(w_pos);
    bottom_q4 = 21'(pos_y_i) + 21'(h_pos);

    // Ceiling of a Q4 value: add fifteen sixteenths, then floor.
    right_up  = 22'(right_q4) + 22'sd15;
    bottom_up = 22'(bottom_q4) + 22'sd15;
    right_px  = right_up[21:4];
    bottom_px = bottom_up[21:4];

    // The floor of the left and top edges is just the integer bits.
    rect_o.x = pos_x_i[19:4];
    rect_o.y = pos_y_i[19:4];

    w_ext = 19'(right_px) - 19'($signed(pos_x_i[19:4]));
    h_ext = 19'(bottom_px) - 19'($signed(pos_y_i[19:4]));
    rect_o.w = sat_u16(w_ext);
    rect_o.h = sat_u16(h_ext);
  end

endmodule

### src/nrcs_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip stack port checker
// Watches the ports of the clip stack over time and binds to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrcs_check (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_stall_o,
  input logic           rsp_valid_o,
  input logic           rsp_stall_i,
  input nrcs_pkg::rsp_t rsp_o
);
  import nrcs_pkg::*;

  // A held response keeps its value until it is taken.
  `NRCS_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))

  // Every accepted request occupies the block in the following cycle.
  `NRCS_ASSERT(a_busy_after_req, clk_i, rst_ni, req_valid_i && !req_stall_o |=> req_stall_o)

  // A new response only appears after the block has been busy with a request.
  `NRCS_ASSERT(a_rsp_from_req, clk_i, rst_ni, $rose(rsp_valid_o) |-> $past(req_stall_o))

  // No response is offered while reset is held.
  `NRCS_ASSERT_ALWAYS(a_rsp_reset, clk_i, !rst_ni |-> !rsp_valid_o)

endmodule

bind nested_clip_rect_stack_unit nrcs_check u_nrcs_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);

### verif/clip_stack_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip stack scoreboard
// Mirrors the nested clip rectangle stack and checks every response in order.
// ----------------------------------------------------------------------------
package clip_stack_check_pkg;
  import nrcs_pkg::*;

  class clip_stack_scoreboard;
    int    depth_limit;
    rect_t shadow_rects[];
    int    shadow_level;
    int    shadow_overflow;
    rsp_t  awaited_rsps[$];
    int    errors;
    int    shown;
    int    n_push;
    int    n_pop;
    int    n_checked;
    int    deepest;
    int    peak_overflow;

    function new(int depth);
      depth_limit     = depth;
      shadow_rects    = new[depth];
      shadow_level    = 0;
      shadow_overflow = 0;
      errors          = 0;
      shown           = 0;
      n_push          = 0;
      n_pop           = 0;
      n_checked       = 0;
      deepest         = 0;
      peak_overflow   = 0;
    endfunction

    // Q16.4 to whole pixels, rounding toward minus infinity.
    function int floor_px(int v);
      return v >>> 4;
    endfunction

    function int ceil_px(int v);
      return -((-v) >>> 4);
    endfunction

    function logic [15:0] clamp_size(int v);
      if (v < 0) begin
        return 16'd0;
      end
      if (v > 65535) begin
        return 16'hFFFF;
      end
      return 16'(v);
    endfunction

    // Works out the response that an accepted request must produce.
    function void note_request(req_t r);
      rsp_t  want;
      rect_t below;
      rect_t fresh;
      int    px, py, sw, sh;
      int    left, top, right_e, bottom_e;
      int    nx, ny, re, be;
      want = '0;
      if (r.req_type == REQ_PUSH) begin
        n_push++;
        if (r.window_ready) begin
          if (shadow_overflow > 0) begin
            if (shadow_overflow < int'(OVF_MAX)) begin
              shadow_overflow++;
            end
          end else if (shadow_level >= depth_limit) begin
            shadow_overflow = 1;
          end else begin
            px       = int'(r.pos_x);
            py       = int'(r.pos_y);
            sw       = (r.size_w < 0) ? 0 : int'(r.size_w);
            sh       = (r.size_h < 0) ? 0 : int'(r.size_h);
            left     = floor_px(px);
            top      = floor_px(py);
            right_e  = ceil_px(px + sw);
            bottom_e = ceil_px(py + sh);
            fresh.x  = 16'(left);
            fresh.y  = 16'(top);
            fresh.w  = clamp_size(right_e - left);
            fresh.h  = clamp_size(bottom_e - top);
            if (shadow_level > 0) begin
              below   = shadow_rects[shadow_level - 1];
              nx      = (int'(below.x) > int'(fresh.x)) ? int'(below.x) : int'(fresh.x);
              ny      = (int'(below.y) > int'(fresh.y)) ? int'(below.y) : int'(fresh.y);
              re      = int'(below.x) + int'(below.w);
              be      = int'(below.y) + int'(below.h);
              if (int'(fresh.x) + int'(fresh.w) < re) re = int'(fresh.x) + int'(fresh.w);
              if (int'(fresh.y) + int'(fresh.h) < be) be = int'(fresh.y) + int'(fresh.h);
              fresh.x = 16'(nx);
              fresh.y = 16'(ny);
              fresh.w = clamp_size(re - nx);
              fresh.h = clamp_size(be - ny);
            end
            shadow_rects[shadow_level] = fresh;
            shadow_level++;
            want.action = ACT_BEGIN;
            want.clip_x = fresh.x;
            want.clip_y = fresh.y;
            want.clip_w = fresh.w;
            want.clip_h = fresh.h;
          end
        end
      end else begin
        n_pop++;
        if (!r.window_ready) begin
          shadow_level    = 0;
          shadow_overflow = 0;
        end else if (shadow_overflow > 0) begin
          shadow_overflow--;
        end else if (shadow_level > 0) begin
          shadow_level--;
          if (shadow_level > 0) begin
            below       = shadow_rects[shadow_level - 1];
            want.action = ACT_END_APPLY;
            want.clip_x = below.x;
            want.clip_y = below.y;
            want.clip_w = below.w;
            want.clip_h = below.h;
          end else begin
            want.action = ACT_END;
          end
        end
      end
      want.stack_level = 7'(shadow_level);
      if (shadow_level > deepest) deepest = shadow_level;
      if (shadow_overflow > peak_overflow) peak_overflow = shadow_overflow;
      awaited_rsps.push_back(want);
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t %s: want act=%0d x=%0d y=%0d w=%0d h=%0d lvl=%0d", $time, what,
                 want.action, want.clip_x, want.clip_y, want.clip_w, want.clip_h,
                 want.stack_level);
        $display("%0t %s:  got act=%0d x=%0d y=%0d w=%0d h=%0d lvl=%0d", $time, what,
                 got.action, got.clip_x, got.clip_y, got.clip_w, got.clip_h,
                 got.stack_level);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsps.size() == 0) begin
        report("unexpected response", '0, got);
        return;
      end
      want = awaited_rsps.pop_front();
      n_checked++;
      if (got.action !== want.action || got.clip_x !== want.clip_x ||
          got.clip_y !== want.clip_y || got.clip_w !== want.clip_w ||
          got.clip_h !== want.clip_h || got.stack_level !== want.stack_level) begin
        report("response mismatch", want, got);
      end
    endfunction

    function int outstanding();
      return awaited_rsps.size();
    endfunction

    // Anything still awaited at the end of the run is a lost response.
    function void finish_check();
      if (awaited_rsps.size() != 0) begin
        $display("%0d responses never arrived", awaited_rsps.size());
        errors += awaited_rsps.size();
      end
    endfunction
  endclass

endpackage

### verif/nested_clip_rect_stack_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested clip rectangle stack testbench
// Drives push and pop requests with random pacing on both sides and checks
// every response against a scoreboard that mirrors the stack.
// ----------------------------------------------------------------------------
module nested_clip_rect_stack_unit_test;
  import nrcs_pkg::*;
  import clip_stack_check_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 1050;
  localparam int OVF_PUSHES   = 6;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b1;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rsp_t rsp_o;

  clip_stack_scoreboard sb;

  // Receiver pacing: the stall probability changes every stretch of cycles.
  // While quiet_rsp is set only light stalling is picked, which keeps the
  // overflow sweep at close to full rate.
  bit quiet_rsp  = 1'b0;
  int stall_pct  = 0;
  int stall_run  = 0;

  // Sender pacing: requests go out in bursts separated by random gaps.
  int burst_left = 0;
  int mode_left  = 150;
  int push_pct   = 92;

  nested_clip_rect_stack_unit #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // The stall pattern picks a new probability for each stretch; a zero
  // probability gives stretches where every response is taken at once.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(16, 160);
      if (quiet_rsp) begin
        stall_pct <= ($urandom_range(1) == 0) ? 0 : 10;
      end else begin
        case ($urandom_range(3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 15;
          2:       stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end
    end else begin
      stall_run <= stall_run - 1;
    end
    rsp_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Responses are sampled at the edge where they are taken; the values read
  // here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      sb.check_response(rsp_o);
    end
  end

  function automatic req_t make_req(req_type_e kind, bit ready, int x, int y, int w, int h);
    req_t r;
    r.req_type     = kind;
    r.window_ready = ready;
    r.pos_x        = 20'(x);
    r.pos_y        = 20'(y);
    r.size_w       = 20'(w);
    r.size_h       = 20'(h);
    return r;
  endfunction

  // Most random rectangles sit in a shared area two thousand pixels wide so
  // that nested pushes overlap; one in four spans the whole Q16.4 range.
  function automatic req_t random_push(bit ready);
    if ($urandom_range(3) == 0) begin
      return make_req(REQ_PUSH, ready, $urandom(), $urandom(), $urandom(), $urandom());
    end
    return make_req(REQ_PUSH, ready,
                    int'($urandom_range(32000)) - 8000, int'($urandom_range(32000)) - 8000,
                    int'($urandom_range(16400)) - 400, int'($urandom_range(16400)) - 400);
  endfunction

  // A window is missing on about one request in thirty-two. Pops carry
  // random rectangle bits, which the block must ignore.
  function automatic req_t random_request(int pct);
    bit ready;
    ready = ($urandom_range(31) != 0);
    if ($urandom_range(99) < pct) begin
      return random_push(ready);
    end
    return make_req(REQ_POP, ready, $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  // Holds the request until it is taken and then hands it to the
  // scoreboard. Valid is left high so that a back-to-back request follows
  // without a dip.
  task automatic send_request(input req_t r);
    req_i       <= r;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(r);
  endtask

  // Ends a burst now and then, with a random gap or with none at all so
  // that some bursts run into each other.
  task automatic drive(input req_t r);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    send_request(r);
  endtask

  initial begin
    sb = new(DEPTH);
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: missing window on both kinds, pop on an empty
    // stack, the field extremes, fractional edges, a zero-size rectangle,
    // an intersection that comes out empty and a pop that ends clipping.
    drive(make_req(REQ_PUSH, 1'b0, 100, 100, 200, 200));
    drive(make_req(REQ_POP, 1'b0, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_PUSH, 1'b1, -524288, -524288, 524287, 524287));
    drive(make_req(REQ_PUSH, 1'b1, 524287, 524287, -524288, -524288));
    drive(make_req(REQ_PUSH, 1'b0, 0, 0, 1600, 1600));
    drive(make_req(REQ_POP, 1'b1, -1, -1, -1, -1));
    drive(make_req(REQ_PUSH, 1'b1, -1, 15, 1, 17));
    drive(make_req(REQ_PUSH, 1'b1, -17, -1, 33, 1));
    drive(make_req(REQ_PUSH, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    drive(make_req(REQ_PUSH, 1'b1, 160, 320, 1600, 800));
    drive(make_req(REQ_PUSH, 1'b1, 8000, 8000, 160, 160));
    drive(make_req(REQ_PUSH, 1'b1, 200, 400, 320, 160));
    drive(make_req(REQ_POP, 1'b0, 0, 0, 0, 0));
    drive(make_req(REQ_PUSH, 1'b1, 524287, 524287, 524287, 524287));
    drive(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));

    // Random requests in phases of mostly pushes, mostly pops or a mix.
    // The first phase is push heavy, so the stack fills and overflows early;
    // later phases drain it again and walk the overflow count back down.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(40, 200);
        case ($urandom_range(3))
          0:       push_pct = 90;
          1:       push_pct = 10;
          2:       push_pct = 50;
          default: push_pct = 70;
        endcase
      end
      mode_left--;
      drive(random_request(push_pct));
    end

    // Overflow sweep: clear the stack, fill it, push a few more so that the
    // overflow count climbs, then pop it back down to zero. The pop after
    // that must bring back the rectangle below the top.
    quiet_rsp = 1'b1;
    send_request(make_req(REQ_POP, 1'b0, 0, 0, 0, 0));
    repeat (DEPTH) send_request(random_push(1'b1));
    repeat (OVF_PUSHES) send_request(random_push(1'b1));
    repeat (OVF_PUSHES) send_request(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    send_request(make_req(REQ_POP, 1'b1, 0, 0, 0, 0));
    send_request(make_req(REQ_POP, 1'b0, 0, 0, 0, 0));
    quiet_rsp = 1'b0;
    req_valid_i <= 1'b0;

    // Drain: every request yields one response, so once nothing is awaited,
    // a further wait shows whether anything extra comes out.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.finish_check();

    $display("Sent %0d pushes and %0d pops; %0d responses checked, %0d errors",
             sb.n_push, sb.n_pop, sb.n_checked, sb.errors);
    $display("Stack reached depth %0d; overflow count peaked at %0d",
             sb.deepest, sb.peak_overflow);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
